/* design/barometer_raw_compensation_defines.svh */
// assertion macros used by the top design file
`ifndef BAROMETER_RAW_COMPENSATION_DEFINES_SVH
`define BAROMETER_RAW_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brc assertion failed");

// next-cycle implication
`define BRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brc assertion failed");

`endif

/* design/brc_pkg.sv */
package brc_pkg;

   // number of register stages from request to response
   localparam int PIPE_STAGES = 11;

   typedef enum logic [1:0] {
      CSR_CALIB_LOW  = 2'd0,
      CSR_CALIB_MID  = 2'd1,
      CSR_CALIB_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_q16;
      logic [31:0]        pressure_q8;
      logic               out_of_range;
   } rsp_type;

   // decoded calibration coefficients (p1, p2 already offset by 2^14)
   typedef struct packed {
      logic [15:0]        t1;
      logic [15:0]        t2;
      logic signed [7:0]  t3;
      logic signed [16:0] p1;
      logic signed [16:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic [15:0]        p5;
      logic [15:0]        p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } coef_type;

   function automatic coef_type decode_coef(input logic [63:0] lo, input logic [63:0] mi,
                                            input logic [39:0] hi);
      coef_type c;
      c.t1  = lo[15:0];
      c.t2  = lo[31:16];
      c.t3  = signed'(lo[39:32]);
      c.p1  = 17'(signed'(lo[55:40])) - 17'sd16384;
      c.p2  = 17'(signed'({mi[7:0], lo[63:56]})) - 17'sd16384;
      c.p3  = signed'(mi[15:8]);
      c.p4  = signed'(mi[23:16]);
      c.p5  = mi[39:24];
      c.p6  = mi[55:40];
      c.p7  = signed'(mi[63:56]);
      c.p8  = signed'(hi[7:0]);
      c.p9  = signed'(hi[23:8]);
      c.p10 = signed'(hi[31:24]);
      c.p11 = signed'(hi[39:32]);
      return c;
   endfunction

endpackage

/* design/brc_csr.sv */
module brc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   output brc_pkg::coef_type   coef
);

   logic [63:0] low_ff;
   logic [63:0] mid_ff;
   logic [39:0] high_ff;

   assign csr_ready = 1'b1;

   // calibration byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         mid_ff  <= '0;
         high_ff <= '0;
      end else if (csr_valid) begin
         case (brc_pkg::csr_index_type'(csr_index))
            brc_pkg::CSR_CALIB_LOW:  low_ff  <= csr_data;
            brc_pkg::CSR_CALIB_MID:  mid_ff  <= csr_data;
            brc_pkg::CSR_CALIB_HIGH: high_ff <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   // coefficient fields out of the byte image
   assign coef = brc_pkg::decode_coef(low_ff, mid_ff, high_ff);

endmodule

/* design/brc_temp.sv */
module brc_temp (
   input  logic               clock,
   input  logic [3:0]         stage_en,
   input  brc_pkg::req_type   req,
   input  brc_pkg::coef_type  coef,
   output logic signed [29:0] tq,
   output logic [23:0]        p
);

   logic signed [25:0] d_ff, d_in;
   logic signed [42:0] m1_ff, m1_in;
   logic signed [51:0] m2_ff, m2_in;
   logic signed [59:0] t3prod;
   logic signed [61:0] n_ff, n_in, rnd;
   logic signed [29:0] tq_ff, tq_in;
   logic [23:0]        p0_ff, p1_ff, p2_ff, p3_ff;

   // offset of raw temperature from t1
   assign d_in = $signed({2'b00, req.raw_temperature}) - $signed({2'b00, coef.t1, 8'h00});

   // linear and square products
   assign m1_in = d_ff * $signed({1'b0, coef.t2});
   assign m2_in = d_ff * d_ff;

   // sum in units of 2^-48 degrees
   assign t3prod = m2_ff * coef.t3;
   assign n_in   = (62'(m1_ff) <<< 18) + 62'(t3prod);

   // round half up to Q16
   assign rnd   = n_ff + 62'sd2147483648;
   assign tq_in = $signed(rnd[61:32]);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff  <= d_in;
         p0_ff <= req.raw_pressure;
      end
      if (stage_en[1]) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         p1_ff <= p0_ff;
      end
      if (stage_en[2]) begin
         n_ff  <= n_in;
         p2_ff <= p1_ff;
      end
      if (stage_en[3]) begin
         tq_ff <= tq_in;
         p3_ff <= p2_ff;
      end
   end

   assign tq = tq_ff;
   assign p  = p3_ff;

endmodule

/* design/brc_press.sv */
module brc_press (
   input  logic               clock,
   input  logic [5:0]         stage_en,
   input  logic signed [29:0] tq_i,
   input  logic [23:0]        p_i,
   input  brc_pkg::coef_type  coef,
   output logic signed [29:0] tq_o,
   output logic signed [63:0] acc
);

   // stage a: powers of t and p
   logic signed [59:0] sq_ff, sq_in;
   logic signed [46:0] u13tq_a_ff, u13tq_in;
   logic signed [46:0] p7tq_a_ff, p7tq_in;
   logic signed [40:0] c3_ff, c3_in;
   logic signed [49:0] pp_ff, pp_in;
   logic signed [29:0] tq_a_ff;
   logic [23:0]        p_a_ff;
   // stage b
   logic signed [43:0] t2q_ff;
   logic signed [65:0] q3_full, c3p_full;
   logic signed [59:0] q3_ff;
   logic signed [57:0] x2a_ff, x2a_in;
   logic signed [60:0] c3p_ff;
   logic signed [46:0] u13tq_b_ff, p7tq_b_ff;
   logic signed [29:0] tq_b_ff;
   logic [23:0]        p_b_ff;
   // stage c
   logic signed [51:0] t3q;
   logic signed [59:0] a_ff, a_in, b_ff, b_in;
   logic signed [51:0] e_ff, e_in, f_ff, f_in;
   logic signed [36:0] x_ff;
   logic signed [58:0] x2p_c_ff, x2p_in;
   logic signed [46:0] u13tq_c_ff, p7tq_c_ff;
   logic signed [29:0] tq_c_ff;
   logic [23:0]        p_c_ff;
   // stage d
   logic signed [63:0] out1_d_ff, out1_in, c2_ff, c2_in;
   logic signed [61:0] xp_d_ff, xp_in;
   logic signed [58:0] x2p_d_ff;
   logic signed [29:0] tq_d_ff;
   logic [23:0]        p_d_ff;
   // stage e
   logic signed [64:0] out2_full;
   logic signed [63:0] out2_ff, out1_e_ff;
   logic signed [61:0] xp_e_ff;
   logic signed [58:0] x2p_e_ff;
   logic signed [29:0] tq_e_ff;
   // stage f
   logic signed [63:0] acc_ff, acc_in;
   logic signed [29:0] tq_f_ff;

   logic signed [24:0] ps_a, ps_b, ps_c, ps_cd, ps_d;

   assign ps_a  = $signed({1'b0, p_i});
   assign ps_b  = $signed({1'b0, p_a_ff});
   assign ps_c  = $signed({1'b0, p_b_ff});
   assign ps_cd = $signed({1'b0, p_c_ff});
   assign ps_d  = $signed({1'b0, p_d_ff});

   // square of t, linear t products, raw pressure square
   assign sq_in    = tq_i * tq_i;
   assign u13tq_in = $signed({1'b0, coef.p6}) * tq_i;
   assign p7tq_in  = coef.p2 * tq_i;
   assign c3_in    = (41'(coef.p9) <<< 16) + 41'(coef.p10 * tq_i);
   assign pp_in    = ps_a * ps_a;

   // cube of t, p11 term, c3 times p
   assign q3_full  = $signed(sq_ff[59:24]) * tq_a_ff;
   assign x2a_in   = coef.p11 * pp_ff;
   assign c3p_full = c3_ff * ps_b;

   // coefficient times powers of t
   assign t3q    = q3_ff[59:8];
   assign a_in   = coef.p8 * t3q;
   assign b_in   = coef.p4 * t3q;
   assign e_in   = coef.p7 * t2q_ff;
   assign f_in   = coef.p3 * t2q_ff;
   assign x2p_in = $signed(x2a_ff[57:24]) * ps_c;

   // temperature sums in Q24 and Q40
   assign out1_in = ($signed(64'(coef.p5)) <<< 27)
                  + (64'(u13tq_c_ff) <<< 2)
                  + 64'(e_ff)
                  + 64'(a_ff >>> 7);
   assign c2_in   = (64'(coef.p1) <<< 20)
                  + 64'(p7tq_c_ff >>> 5)
                  + 64'(f_ff >>> 8)
                  + 64'(b_ff >>> 13);
   assign xp_in   = x_ff * ps_cd;

   // p1..p4 sum times p
   assign out2_full = $signed(c2_ff[47:8]) * ps_d;

   // final Q24 sum
   assign acc_in = out1_e_ff + (out2_ff >>> 8) + 64'(xp_e_ff >>> 16) + 64'(x2p_e_ff >>> 17);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_ff      <= sq_in;
         u13tq_a_ff <= u13tq_in;
         p7tq_a_ff  <= p7tq_in;
         c3_ff      <= c3_in;
         pp_ff      <= pp_in;
         tq_a_ff    <= tq_i;
         p_a_ff     <= p_i;
      end
      if (stage_en[1]) begin
         t2q_ff     <= sq_ff[59:16];
         q3_ff      <= q3_full[59:0];
         x2a_ff     <= x2a_in;
         c3p_ff     <= c3p_full[60:0];
         u13tq_b_ff <= u13tq_a_ff;
         p7tq_b_ff  <= p7tq_a_ff;
         tq_b_ff    <= tq_a_ff;
         p_b_ff     <= p_a_ff;
      end
      if (stage_en[2]) begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         e_ff       <= e_in;
         f_ff       <= f_in;
         x_ff       <= c3p_ff[60:24];
         x2p_c_ff   <= x2p_in;
         u13tq_c_ff <= u13tq_b_ff;
         p7tq_c_ff  <= p7tq_b_ff;
         tq_c_ff    <= tq_b_ff;
         p_c_ff     <= p_b_ff;
      end
      if (stage_en[3]) begin
         out1_d_ff <= out1_in;
         c2_ff     <= c2_in;
         xp_d_ff   <= xp_in;
         x2p_d_ff  <= x2p_c_ff;
         tq_d_ff   <= tq_c_ff;
         p_d_ff    <= p_c_ff;
      end
      if (stage_en[4]) begin
         out2_ff   <= out2_full[63:0];
         out1_e_ff <= out1_d_ff;
         xp_e_ff   <= xp_d_ff;
         x2p_e_ff  <= x2p_d_ff;
         tq_e_ff   <= tq_d_ff;
      end
      if (stage_en[5]) begin
         acc_ff  <= acc_in;
         tq_f_ff <= tq_e_ff;
      end
   end

   assign acc  = acc_ff;
   assign tq_o = tq_f_ff;

endmodule

/* design/barometer_raw_compensation.sv */
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_data (brc_pkg::req_type)
// rsp       out        rsp_valid/rsp_ready    rsp_data (brc_pkg::rsp_type)
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one request per cycle while req_ready is high; a request reaches the
// response register through the chain t -> t^2 -> t^3 -> sums -> times p
// reset clears the stage valid bits and the calibration registers to zero
// a stalled response holds the last stage; bubbles ahead of it still fill
// csr writes are always taken; csr_ready is tied high
module barometer_raw_compensation (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brc_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

`include "barometer_raw_compensation_defines.svh"

   localparam int NS = brc_pkg::PIPE_STAGES;

   brc_pkg::coef_type coef;
   logic [NS-1:0]      v_ff, v_in, en;
   logic signed [29:0] tq_t, tq_p;
   logic [23:0]        p_t;
   logic signed [63:0] acc;
   logic signed [63:0] pq_w;
   logic signed [47:0] pq;
   brc_pkg::rsp_type   rsp_ff, rsp_in;

   brc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   brc_temp u_temp (
      .clock    (clock),
      .stage_en (en[3:0]),
      .req      (req_data),
      .coef     (coef),
      .tq       (tq_t),
      .p        (p_t)
   );

   brc_press u_press (
      .clock    (clock),
      .stage_en (en[9:4]),
      .tq_i     (tq_t),
      .p_i      (p_t),
      .coef     (coef),
      .tq_o     (tq_p),
      .acc      (acc)
   );

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = {v_ff[NS-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // round pressure to Q8 and saturate
   assign pq_w = acc + 64'sd32768;
   assign pq   = pq_w[63:16];

   always_comb begin
      rsp_in.temperature_q16 = 32'(tq_p);
      if (pq[47]) begin
         rsp_in.pressure_q8  = '0;
         rsp_in.out_of_range = 1'b1;
      end else if (|pq[46:32]) begin
         rsp_in.pressure_q8  = '1;
         rsp_in.out_of_range = 1'b1;
      end else begin
         rsp_in.pressure_q8  = pq[31:0];
         rsp_in.out_of_range = 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];
   assign rsp_data  = rsp_ff;

   `BRC_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, v_ff[0])
   `BRC_ASSERT_NOW(a_full_when_blocked, clock, reset, !req_ready, &v_ff)
   `BRC_ASSERT_NOW(a_flag_saturates, clock, reset, rsp_valid && rsp_data.out_of_range,
                   rsp_data.pressure_q8 == 32'h0 || rsp_data.pressure_q8 == 32'hFFFFFFFF)
   `BRC_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, v_ff == '0)

endmodule

/* tb/sv/barometer_raw_compensation_tb.sv */
`timescale 1ns / 100ps

module barometer_raw_compensation_tb;

   // index with no register behind it, writes are dropped
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = brc_pkg::PIPE_STAGES + 6;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   brc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   brc_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = brc_pkg::CSR_CALIB_LOW;
   logic [63:0]      csr_data = '0;

   // testbench copy of the calibration registers
   logic [63:0]      calib_low = '0;
   logic [63:0]      calib_mid = '0;
   logic [39:0]      calib_high = '0;

   brc_pkg::rsp_type expected_results[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               hold_left = 0;

   barometer_raw_compensation uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("barometer_raw_compensation_tb: FAIL");
         $finish;
      end
   end

   // receiver ready, with random idling and long hold-offs
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // calibration byte access over the 21 bytes
   function automatic longint calib_byte(input int i);
      logic [167:0] all;
      all = {calib_high, calib_mid, calib_low};
      return longint'(all[8*i +: 8]);
   endfunction

   function automatic longint calib_u16(input int i);
      return calib_byte(i) | (calib_byte(i + 1) << 8);
   endfunction

   function automatic longint calib_s16(input int i);
      logic signed [15:0] v;
      v = 16'(calib_u16(i));
      return longint'(v);
   endfunction

   function automatic longint calib_s8(input int i);
      logic signed [7:0] v;
      v = 8'(calib_byte(i));
      return longint'(v);
   endfunction

   // compensated temperature and pressure for one raw sample
   function automatic brc_pkg::rsp_type compensate(input brc_pkg::req_type r);
      brc_pkg::rsp_type res;
      longint p, d, n, tq, t2q, t3q, out1, c2, out2, c3, x, out3, acc, pq;
      logic flag;
      flag = 1'b0;
      p = longint'(r.raw_pressure);
      d = longint'(r.raw_temperature) - calib_u16(0) * 256;
      n = d * calib_u16(2) * 262144 + d * d * calib_s8(4);
      tq = (n + 64'sd2147483648) >>> 32;
      if (tq > 64'sd2147483647) begin
         tq = 64'sd2147483647;
         flag = 1'b1;
      end
      if (tq < -64'sd2147483648) begin
         tq = -64'sd2147483648;
         flag = 1'b1;
      end
      t2q = (tq * tq) >>> 16;
      t3q = ((t2q >>> 8) * tq) >>> 8;
      // offset terms in Q24
      out1 = calib_u16(11) * 64'sd134217728 + calib_u16(13) * tq * 4
           + calib_s8(15) * t2q + ((calib_s8(16) * t3q) >>> 7);
      // sensitivity terms, scaled by raw pressure
      c2 = (calib_s16(5) - 16384) * 64'sd1048576
         + (((calib_s16(7) - 16384) * tq) >>> 5)
         + ((calib_s8(9) * t2q) >>> 8)
         + ((calib_s8(10) * t3q) >>> 13);
      out2 = ((c2 >>> 8) * p) >>> 8;
      // square and cube terms in raw pressure
      c3 = calib_s16(17) * 65536 + calib_s8(19) * tq;
      x = (c3 * p) >>> 24;
      out3 = (x * p) >>> 16;
      x = (calib_s8(20) * p * p) >>> 24;
      out3 += (x * p) >>> 17;
      acc = out1 + out2 + out3;
      pq = (acc + 64'sd32768) >>> 16;
      res.temperature_q16 = 32'(tq);
      if (pq < 0) begin
         res.pressure_q8 = 32'h0;
         flag = 1'b1;
      end else if (pq > 64'sd4294967295) begin
         res.pressure_q8 = 32'hFFFF_FFFF;
         flag = 1'b1;
      end else begin
         res.pressure_q8 = 32'(pq);
      end
      res.out_of_range = flag;
      return res;
   endfunction

   // response checker
   always @(posedge clock) begin
      brc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", rsp_data);
         end else begin
            want = expected_results.pop_front();
            if (want.temperature_q16 !== rsp_data.temperature_q16
                || want.pressure_q8 !== rsp_data.pressure_q8
                || want.out_of_range !== rsp_data.out_of_range) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp t=%h p=%h f=%b got t=%h p=%h f=%b",
                           want.temperature_q16, want.pressure_q8, want.out_of_range,
                           rsp_data.temperature_q16, rsp_data.pressure_q8,
                           rsp_data.out_of_range);
            end
         end
      end
   end

   // send one request, with a random gap ahead of it
   task automatic send_sample(input logic [23:0] pres, input logic [23:0] temp);
      brc_pkg::req_type r;
      r.raw_pressure = pres;
      r.raw_temperature = temp;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      expected_results.push_back(compensate(r));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         brc_pkg::CSR_CALIB_LOW:  calib_low = value;
         brc_pkg::CSR_CALIB_MID:  calib_mid = value;
         brc_pkg::CSR_CALIB_HIGH: calib_high = value[39:0];
         default: ;
      endcase
   endtask

   task automatic write_calib(input logic [63:0] lo, input logic [63:0] mi,
                              input logic [63:0] hi);
      write_csr(brc_pkg::CSR_CALIB_LOW, lo);
      write_csr(brc_pkg::CSR_CALIB_MID, mi);
      write_csr(brc_pkg::CSR_CALIB_HIGH, hi);
   endtask

   // calibration close to a real part, with random spread
   task automatic write_typical_calib();
      logic [15:0] t1, t2, p1, p2, p5, p6, p9;
      t1 = 16'h6800 + 16'($urandom_range(4095));
      t2 = 16'h4800 + 16'($urandom_range(4095));
      p1 = 16'hF000 + 16'($urandom_range(8191));
      p2 = 16'hF000 + 16'($urandom_range(8191));
      p5 = 16'h6400 + 16'($urandom_range(4095));
      p6 = 16'h5800 + 16'($urandom_range(4095));
      p9 = 16'h1000 + 16'($urandom_range(4095));
      write_calib({p2[7:0], p1, 8'($urandom_range(15) - 8), t2, t1},
                  {8'($urandom_range(15)), p6, p5, 8'($urandom_range(31) - 16),
                   8'($urandom_range(15)), p2[15:8]},
                  {24'($urandom), 8'($urandom_range(7)), 8'($urandom_range(15)), p9,
                   8'($urandom_range(31) - 16)});
   endtask

   task automatic send_random_sample();
      logic [23:0] temp;
      if ($urandom_range(3) == 0) begin
         send_sample(24'($urandom), 24'($urandom));
      end else begin
         temp = 24'(calib_u16(0) * 256 + $urandom_range(2000000) - 1000000);
         send_sample(24'h500000 + 24'($urandom_range(3000000)), temp);
      end
   endtask

   // all-zero calibration after reset: negative pressure for a nonzero raw pressure
   task automatic test_reset_calibration();
      send_sample(24'h000000, 24'h000000);
      send_sample(24'hFFFFFF, 24'hFFFFFF);
      send_sample(24'h800000, 24'h123456);
      wait_drained();
   endtask

   // field extremes and the special cases
   task automatic test_directed();
      write_typical_calib();
      send_sample(24'h000000, 24'h000000);
      send_sample(24'hFFFFFF, 24'hFFFFFF);
      send_sample(24'h000000, 24'hFFFFFF);
      send_sample(24'hFFFFFF, 24'h000000);
      send_sample(24'h6A0000, 24'(calib_u16(0) * 256));
      send_sample(24'h6A0000, 24'(calib_u16(0) * 256 - 1));
      send_sample(24'h6A0000, 24'(calib_u16(0) * 256 + 1));
      wait_drained();
      // all-ones calibration: a negative pressure saturates to zero
      write_calib('1, '1, '1);
      send_sample(24'h000000, 24'h000000);
      send_sample(24'hFFFFFF, 24'hFFFFFF);
      send_sample(24'h7FFFFF, 24'h800000);
      wait_drained();
      // large offset coefficient gives a large pressure that stays within the output range
      write_calib(64'h0000_4000_0000_0000, 64'h0000_FFFF_FFFF_0000, 64'h0);
      send_sample(24'h000000, 24'h000000);
      send_sample(24'hFFFFFF, 24'h000100);
      wait_drained();
      // write to the unmapped index leaves calibration unchanged
      write_typical_calib();
      write_csr(CSR_UNMAPPED, '1);
      send_sample(24'h654321, 24'(calib_u16(0) * 256 + 5000));
      send_sample(24'h123456, 24'h876543);
      wait_drained();
   endtask

   task automatic test_random_phase(input int sidle, input int ridle, input int count);
      send_idle_pct = sidle;
      rsp_idle_pct = ridle;
      if ($urandom_range(1) == 0)
         write_typical_calib();
      else
         write_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      repeat (count) send_random_sample();
      wait_drained();
   endtask

   // long receiver stall while the sender keeps going
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = 300;
      repeat (40) send_random_sample();
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_directed();
      test_random_phase(7, 68, 83);
      test_random_phase(7, 68, 83);
      test_random_phase(68, 7, 83);
      test_random_phase(68, 7, 83);
      test_random_phase(0, 0, 83);
      test_random_phase(0, 0, 83);
      test_backpressure();
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("barometer_raw_compensation_tb: PASS");
      else
         $display("barometer_raw_compensation_tb: FAIL");
      $finish;
   end

endmodule
